// ===== hdl/ubxrx_pkg.sv =====
// Shared types, codes and sizing constants for the binary frame receiver.
package ubxrx_pkg;

    localparam int MAX_PAYLOAD = 255;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int POS_W       = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_SYNC2 = 3'd1,
        ERR_OVERRUN   = 3'd2,
        ERR_TOO_LONG  = 3'd3,
        ERR_CK_A      = 3'd4,
        ERR_CK_B      = 3'd5
    } err_code_t;

    typedef enum logic [1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1
    } cfg_index_t;

    // Result of one step, minus the payload byte, which comes from the buffer.
    typedef struct packed {
        logic       frame_done;
        err_code_t  error_code;
        logic       frame_pending;
        logic [7:0] frame_class;
        logic [7:0] frame_ident;
        logic [7:0] frame_length;
        logic [7:0] overrun_count;
        logic       rd_ok;
    } result_t;

endpackage

// ===== hdl/ubxrx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ubxrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/ubxrx_parser.sv =====
// Frame parser: sync hunt, header capture, Fletcher checksum and pending control.
module ubxrx_parser
    import ubxrx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  opcode_t           opcode,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        read_index,
    input  logic [7:0]        sync_first,
    input  logic [7:0]        sync_second,
    output result_t           res,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr
);

    typedef enum logic [8:0] {
        PH_HUNT    = 9'b000000001,
        PH_SYNC1   = 9'b000000010,
        PH_SYNC2   = 9'b000000100,
        PH_CLASS   = 9'b000001000,
        PH_IDENT   = 9'b000010000,
        PH_LEN1    = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CKA     = 9'b010000000,
        PH_CKB     = 9'b100000000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;
    logic [7:0]       class_reg, class_next;
    logic [7:0]       ident_reg, ident_next;
    logic [15:0]      length_reg, length_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             pending_reg, pending_next;
    logic [7:0]       overrun_reg, overrun_next;

    logic [7:0]       add_a, add_b;
    logic [POS_W-1:0] pos_inc;
    logic [15:0]      len_full;
    logic             receive;
    logic             done;
    err_code_t        err;

    assign receive = (opcode == OP_RECEIVE);
    assign add_a   = sum_a_reg + data_byte;
    assign add_b   = sum_b_reg + add_a;
    assign pos_inc = pos_reg + POS_W'(1);
    assign len_full = {data_byte, length_reg[7:0]};

    always_comb begin
        phase_next   = phase_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        class_next   = class_reg;
        ident_next   = ident_reg;
        length_next  = length_reg;
        pos_next     = pos_reg;
        pending_next = pending_reg;
        overrun_next = overrun_reg;
        done         = 1'b0;
        err          = ERR_NONE;
        wr_en        = 1'b0;

        unique case (opcode)
            OP_RECEIVE: begin
                if (phase_reg != PH_CKA && phase_reg != PH_CKB) begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                end
                unique case (phase_reg)
                    PH_HUNT: begin
                        if (data_byte == sync_first) begin
                            phase_next = PH_SYNC1;
                        end
                    end
                    PH_SYNC1: begin
                        if (data_byte != sync_second) begin
                            err        = ERR_BAD_SYNC2;
                            phase_next = PH_HUNT;
                        end else begin
                            sum_a_next = '0;
                            sum_b_next = '0;
                            phase_next = PH_SYNC2;
                        end
                    end
                    PH_SYNC2: begin
                        // drop the new frame while one is still held
                        if (pending_reg) begin
                            overrun_next = overrun_reg + 8'd1;
                            err          = ERR_OVERRUN;
                            phase_next   = PH_HUNT;
                        end else begin
                            class_next = data_byte;
                            phase_next = PH_CLASS;
                        end
                    end
                    PH_CLASS: begin
                        ident_next = data_byte;
                        phase_next = PH_IDENT;
                    end
                    PH_IDENT: begin
                        length_next = {8'd0, data_byte};
                        phase_next  = PH_LEN1;
                    end
                    PH_LEN1: begin
                        length_next = len_full;
                        if (len_full > 16'(MAX_PAYLOAD)) begin
                            err        = ERR_TOO_LONG;
                            phase_next = PH_HUNT;
                        end else begin
                            pos_next   = '0;
                            phase_next = (len_full == 16'd0) ? PH_CKA : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        wr_en    = (16'(pos_reg) < 16'(MAX_PAYLOAD));
                        pos_next = pos_inc;
                        if (16'(pos_inc) >= length_reg) begin
                            phase_next = PH_CKA;
                        end
                    end
                    PH_CKA: begin
                        if (data_byte != sum_a_reg) begin
                            err        = ERR_CK_A;
                            phase_next = PH_HUNT;
                        end else begin
                            phase_next = PH_CKB;
                        end
                    end
                    PH_CKB: begin
                        if (data_byte != sum_b_reg) begin
                            err = ERR_CK_B;
                        end else begin
                            pending_next = 1'b1;
                            done         = 1'b1;
                        end
                        phase_next = PH_HUNT;
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
            OP_RELEASE: begin
                pending_next = 1'b0;
            end
            OP_READ, OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    assign wr_addr = pos_reg[ADDR_W-1:0];
    assign wr_data = data_byte;
    assign rd_en   = res.rd_ok;
    assign rd_addr = ADDR_W'(read_index);

    always_comb begin
        res.frame_done    = done;
        res.error_code    = err;
        res.frame_pending = pending_next;
        res.frame_class   = class_next;
        res.frame_ident   = ident_next;
        res.frame_length  = length_next[7:0];
        res.overrun_count = overrun_next;
        res.rd_ok         = (opcode == OP_READ) && (16'(read_index) < 16'(MAX_PAYLOAD));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            sum_a_reg   <= '0;
            sum_b_reg   <= '0;
            class_reg   <= '0;
            ident_reg   <= '0;
            length_reg  <= '0;
            pos_reg     <= '0;
            pending_reg <= 1'b0;
            overrun_reg <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            class_reg   <= class_next;
            ident_reg   <= ident_next;
            length_reg  <= length_next;
            pos_reg     <= pos_next;
            pending_reg <= pending_next;
            overrun_reg <= overrun_next;
        end
    end

    a_done_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        step && receive && done |=> pending_reg)
        else $error("completed frame did not set pending");

    a_overrun_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && receive && err == ERR_OVERRUN |=> overrun_reg == $past(overrun_reg) + 8'd1)
        else $error("overrun drop not counted");

    a_payload_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> 16'(pos_reg) < length_reg)
        else $error("payload position ran past length");

endmodule

// ===== hdl/ubx_frame_receiver_top.sv =====
// Top level of the binary frame receiver: config registers, buffer and output pipeline.
//
// The block takes one item per clock cycle, unless the output stalls, on the s_ channel:
// a received byte, a release of the pending frame, or a read of a payload byte. Each item
// yields one result on the m_ channel via stage one, beside the buffer's registered read
// port, and the output register. Parser state, checksums and header fields update in the
// cycle of the transfer, so results reflect the state after that item. The buffer is not
// cleared at reset; reading a position never written by a frame returns an undefined byte,
// and a read index at or beyond the buffer depth returns zero. Sync bytes are written
// on the cfg_ channel, which is always ready; write them only while no item is in flight.
module ubx_frame_receiver_top
    import ubxrx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_data_byte,
    input  logic [7:0] s_read_index,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_frame_done,
    output logic [2:0] m_error_code,
    output logic       m_frame_pending,
    output logic [7:0] m_frame_class,
    output logic [7:0] m_frame_ident,
    output logic [7:0] m_frame_length,
    output logic [7:0] m_overrun_count,
    output logic [7:0] m_read_data
);

    logic [7:0]        sync_first_reg;
    logic [7:0]        sync_second_reg;

    logic              accept;
    logic              out_free;
    logic              st1_adv;
    logic              st1_valid_reg;
    result_t           st1_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic [7:0]        out_data_reg;

    result_t           res;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= 8'd181;
            sync_second_reg <= 8'd98;
        end else if (cfg_valid) begin
            priority if (cfg_index == CFG_SYNC_FIRST) begin
                sync_first_reg <= cfg_data;
            end else if (cfg_index == CFG_SYNC_SECOND) begin
                sync_second_reg <= cfg_data;
            end
        end
    end

    // Stage one holds while the output register is full and not taken.
    assign out_free = !out_valid_reg || m_ready;
    assign st1_adv  = st1_valid_reg && out_free;
    assign s_ready  = !st1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    ubxrx_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .opcode      (opcode_t'(s_opcode)),
        .data_byte   (s_data_byte),
        .read_index  (s_read_index),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .res         (res),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr)
    );

    ubxrx_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (accept && wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept && rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st1_valid_reg <= 1'b1;
            end else if (st1_adv) begin
                st1_valid_reg <= 1'b0;
            end
            if (st1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg <= res;
        end
        if (st1_adv) begin
            out_reg      <= st1_reg;
            out_data_reg <= st1_reg.rd_ok ? rd_data : 8'd0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_done    = out_reg.frame_done;
    assign m_error_code    = out_reg.error_code;
    assign m_frame_pending = out_reg.frame_pending;
    assign m_frame_class   = out_reg.frame_class;
    assign m_frame_ident   = out_reg.frame_ident;
    assign m_frame_length  = out_reg.frame_length;
    assign m_overrun_count = out_reg.overrun_count;
    assign m_read_data     = out_data_reg;

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> st1_valid_reg)
        else $error("accepted transfer lost before stage one");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && out_valid_reg && !m_ready |=> st1_valid_reg && $stable(st1_reg))
        else $error("stage one changed while stalled");

    a_done_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.frame_done |-> out_reg.error_code == ERR_NONE
            && out_reg.frame_pending)
        else $error("completed frame reported with error or not pending");

endmodule
